// ===== rtl/seeded_crc32_report_trailer_top_defines.svh =====
// ----------------------------------------------------------------------------
// seeded crc32 report trailer assertion macros
// shared property macros for the port checker
// ----------------------------------------------------------------------------
`ifndef SEEDED_CRC32_REPORT_TRAILER_TOP_DEFINES_SVH
`define SEEDED_CRC32_REPORT_TRAILER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SRCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srct assertion failed");

// next-cycle implication, checked outside reset
`define SRCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srct assertion failed");

`endif

// ===== rtl/srct_pkg.sv =====
// ----------------------------------------------------------------------------
// srct_pkg
// shared types, constants and crc fold function for the report trailer
// ----------------------------------------------------------------------------
`default_nettype none

package srct_pkg;

  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] SEED_OUTPUT  = 32'hEADA_2D49;
  localparam logic [31:0] SEED_FEATURE = 32'h2060_EFC3;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam int TRAILER_BYTES = 4;
  localparam int TAW           = $clog2(TRAILER_BYTES);

  typedef struct packed {
    logic [7:0]  body_byte;
    logic        body_last;
    logic [31:0] final_crc;
  } srct_entry_t;

  // one byte folded lsb first into a reflected crc register
  function automatic logic [31:0] fold_byte(input logic [31:0] crc,
                                            input logic [7:0]  b);
    logic [31:0] r;
    r = crc ^ {24'b0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/srct_front.sv =====
// ----------------------------------------------------------------------------
// srct_front
// accepts body bytes, folds them into the crc and queues one entry per byte
// ----------------------------------------------------------------------------
`default_nettype none

module srct_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [31:0]         cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          in_body_byte,
  input  wire logic                in_body_last,
  input  wire logic                q_full,
  output logic                     q_push,
  output srct_pkg::srct_entry_t    q_entry
);
  import srct_pkg::*;

  logic [31:0] seed_r, seed_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] folded;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign folded   = fold_byte(crc_r, in_body_byte);

  assign q_entry.body_byte = in_body_byte;
  assign q_entry.body_last = in_body_last;
  assign q_entry.final_crc = ~folded;

  always_comb begin
    seed_nxt = seed_r;
    crc_nxt  = crc_r;
    if (cfg_wr_en) begin
      seed_nxt = cfg_wr_data;
      crc_nxt  = ~cfg_wr_data;
    end else if (q_push) begin
      crc_nxt = in_body_last ? ~seed_r : folded;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_OUTPUT;
      crc_r  <= ~SEED_OUTPUT;
    end else begin
      seed_r <= seed_nxt;
      crc_r  <= crc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/srct_queue.sv =====
// ----------------------------------------------------------------------------
// srct_queue
// small fifo of classified entries between the front and back ends
// ----------------------------------------------------------------------------
`default_nettype none

module srct_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire srct_pkg::srct_entry_t push_entry,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       head_valid,
  output srct_pkg::srct_entry_t      head_entry
);
  import srct_pkg::*;

  srct_entry_t    mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;

  assign full       = (count_r == QDEPTH[QAW:0]);
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/srct_back.sv =====
// ----------------------------------------------------------------------------
// srct_back
// emits the echo of each entry and the four crc trailer bytes after the last
// ----------------------------------------------------------------------------
`default_nettype none

module srct_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  head_valid,
  input  wire srct_pkg::srct_entry_t head_entry,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_byte,
  output logic                       out_is_crc,
  output logic                       out_last
);
  import srct_pkg::*;

  typedef enum logic {
    ST_ECHO,
    ST_TRAILER
  } state_t;

  state_t         state_r;
  logic [31:0]    crc_r;
  logic [TAW-1:0] idx_r;
  logic           valid_r;
  logic [7:0]     byte_r;
  logic           is_crc_r;
  logic           last_r;
  logic           can_load;
  logic [7:0]     trailer_byte;

  assign can_load     = !valid_r || !out_stall;
  assign pop          = can_load && (state_r == ST_ECHO) && head_valid;
  assign trailer_byte = crc_r[{idx_r, 3'b000} +: 8];

  assign out_valid  = valid_r;
  assign out_byte   = byte_r;
  assign out_is_crc = is_crc_r;
  assign out_last   = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ECHO;
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (can_load) begin
      case (state_r)
        ST_TRAILER: begin
          valid_r  <= 1'b1;
          byte_r   <= trailer_byte;
          is_crc_r <= 1'b1;
          last_r   <= (idx_r == TAW'(TRAILER_BYTES - 1));
          idx_r    <= idx_r + 1'b1;
          if (idx_r == TAW'(TRAILER_BYTES - 1)) begin
            state_r <= ST_ECHO;
          end
        end
        ST_ECHO: begin
          valid_r <= head_valid;
          if (head_valid) begin
            byte_r   <= head_entry.body_byte;
            is_crc_r <= 1'b0;
            last_r   <= 1'b0;
            if (head_entry.body_last) begin
              crc_r   <= head_entry.final_crc;
              idx_r   <= '0;
              state_r <= ST_TRAILER;
            end
          end
        end
        default: begin
          state_r <= ST_ECHO;
          valid_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/seeded_crc32_report_trailer_top.sv =====
// ----------------------------------------------------------------------------
// seeded_crc32_report_trailer_top
// report body echo with a seeded reflected crc-32 trailer
// ----------------------------------------------------------------------------
// Body bytes are taken at one per cycle while in_stall is low and echoed
// unchanged; the byte flagged as last is followed by the inverted reflected
// CRC-32 (poly 0xEDB88320) as four trailer bytes, least significant first,
// the final one marked out_last. Each report's CRC starts from the inverse
// of cfg seed (reset 0xEADA2D49); writing the seed also restarts the running
// CRC. A report of N body bytes leaves as N+4 output transactions at one per
// cycle while out_stall is low, set by the back end's single output register;
// the front end folds one byte per cycle and feeds a 4-entry queue, so input
// stalls only while it is full. Bytes pass the queue, then the output register.
`default_nettype none

module seeded_crc32_report_trailer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_body_byte,
  input  wire logic        in_body_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_is_crc,
  output logic             out_last
);
  import srct_pkg::*;

  srct_entry_t push_entry;
  srct_entry_t head_entry;
  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_head_valid;

  srct_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_body_byte (in_body_byte),
    .in_body_last (in_body_last),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (push_entry)
  );

  srct_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_entry (head_entry)
  );

  srct_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_entry (head_entry),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_is_crc (out_is_crc),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire

// ===== rtl/srct_checker.sv =====
// ----------------------------------------------------------------------------
// srct_checker
// port-level checks on the result channel of the report trailer
// ----------------------------------------------------------------------------
`default_nettype none

`include "seeded_crc32_report_trailer_top_defines.svh"

module srct_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       out_is_crc,
  input wire logic       out_last
);

  `SRCT_ASSERT_NEXT(a_valid_holds, out_valid && out_stall, out_valid)
  `SRCT_ASSERT_NEXT(a_payload_holds, out_valid && out_stall, $stable({out_byte, out_is_crc, out_last}))
  `SRCT_ASSERT_NOW(a_last_is_crc, out_valid && out_last, out_is_crc)
  `SRCT_ASSERT_NEXT(a_trailer_runs, out_valid && !out_stall && out_is_crc && !out_last, out_valid && out_is_crc)

endmodule

bind seeded_crc32_report_trailer_top srct_checker u_srct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_byte   (out_byte),
  .out_is_crc (out_is_crc),
  .out_last   (out_last)
);

`default_nettype wire
